### design/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared sizes, codes and types for the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Store size and derived widths
  localparam int unsigned CAPACITY   = 128;
  localparam int unsigned ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned POS_W      = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 8;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Result status, also used as the classified operation
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Input operation kind
  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  // Classified command: operation, value and entry count after it
  typedef struct packed {
    status_e                    op;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           cnt;
  } cmd_t;

  // Result item
  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  top_value;
    logic [COUNT_W-1:0]         count;
  } res_t;

endpackage

### design/mhpq_in_if.sv
// ----------------------------------------------------------------------------
// mhpq_in_if
// Request channel: operation kind and value with valid/ready.
// ----------------------------------------------------------------------------
interface mhpq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [mhpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

### design/mhpq_out_if.sv
// ----------------------------------------------------------------------------
// mhpq_out_if
// Result channel: status, removed maximum and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface mhpq_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [mhpq_pkg::VALUE_W-1:0] top_value;
  logic [mhpq_pkg::COUNT_W-1:0]       count;

  modport source (output valid, status, top_value, count, input ready);
  modport sink   (input valid, status, top_value, count, output ready);
endinterface

### design/mhpq_front.sv
// ----------------------------------------------------------------------------
// mhpq_front
// Accepts requests and classifies them against a running entry count, so
// that full/empty outcomes and the final count are known up front.
// ----------------------------------------------------------------------------
module mhpq_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_kind_i,
  input  logic signed [mhpq_pkg::VALUE_W-1:0] in_value_i,
  output logic                                in_ready_o,
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output mhpq_pkg::cmd_t                      cmd_o
);

  logic [mhpq_pkg::POS_W-1:0] cnt_q, cnt_d;
  logic                       accept;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i & cmd_ready_i;

  // Classify and compute count after the operation
  always_comb begin
    cmd_o.value = in_value_i;
    cmd_o.op    = mhpq_pkg::ST_INSERTED;
    cmd_o.cnt   = cnt_q;
    if (in_kind_i == mhpq_pkg::KIND_ENQ) begin
      if (cnt_q == mhpq_pkg::POS_W'(mhpq_pkg::CAPACITY)) begin
        cmd_o.op = mhpq_pkg::ST_FULL;
      end else begin
        cmd_o.op  = mhpq_pkg::ST_INSERTED;
        cmd_o.cnt = cnt_q + mhpq_pkg::POS_W'(1);
      end
    end else begin
      if (cnt_q == '0) begin
        cmd_o.op = mhpq_pkg::ST_EMPTY;
      end else begin
        cmd_o.op  = mhpq_pkg::ST_DEQUEUED;
        cmd_o.cnt = cnt_q - mhpq_pkg::POS_W'(1);
      end
    end
    cnt_d = accept ? cmd_o.cnt : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### design/mhpq_cmdq.sv
// ----------------------------------------------------------------------------
// mhpq_cmdq
// Small FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module mhpq_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  mhpq_pkg::cmd_t wr_cmd_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output mhpq_pkg::cmd_t rd_cmd_o
);

  mhpq_pkg::cmd_t                  slot_q [mhpq_pkg::CMDQ_DEPTH];
  logic [mhpq_pkg::CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mhpq_pkg::CMDQ_CNT_W-1:0] fill_q, fill_d;
  logic                            push, pop;

  function automatic logic [mhpq_pkg::CMDQ_PTR_W-1:0] ptr_inc(
    input logic [mhpq_pkg::CMDQ_PTR_W-1:0] p
  );
    if (p == mhpq_pkg::CMDQ_PTR_W'(mhpq_pkg::CMDQ_DEPTH - 1)) begin
      return '0;
    end
    return p + mhpq_pkg::CMDQ_PTR_W'(1);
  endfunction

  assign wr_ready_o = (fill_q != mhpq_pkg::CMDQ_CNT_W'(mhpq_pkg::CMDQ_DEPTH));
  assign rd_valid_o = (fill_q != '0);
  assign rd_cmd_o   = slot_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + mhpq_pkg::CMDQ_CNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - mhpq_pkg::CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

### design/mhpq_back.sv
// ----------------------------------------------------------------------------
// mhpq_back
// Heap engine: holds the store, runs sift-up and sift-down one level per
// read/compare pair, and keeps the result register.
// ----------------------------------------------------------------------------
module mhpq_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  mhpq_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mhpq_pkg::res_t out_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_UP_CMP  = 6'b000010,
    S_DN_LOAD = 6'b000100,
    S_DN_CMP  = 6'b001000,
    S_PLACE   = 6'b010000,
    S_RESP    = 6'b100000
  } state_e;

  state_e                              state_q, state_d;
  mhpq_pkg::status_e                   op_q, op_d;
  logic signed [mhpq_pkg::VALUE_W-1:0] val_q, val_d;
  logic signed [mhpq_pkg::VALUE_W-1:0] top_q, top_d;
  logic [mhpq_pkg::POS_W-1:0]          cnt_q, cnt_d;
  logic [mhpq_pkg::POS_W-1:0]          pos_q, pos_d;
  mhpq_pkg::res_t                      out_q;
  logic                                out_valid_q, out_valid_d;
  logic                                out_load;

  // Heap store with one write and two registered read ports
  logic signed [mhpq_pkg::VALUE_W-1:0] mem_q [mhpq_pkg::CAPACITY];
  logic signed [mhpq_pkg::VALUE_W-1:0] rd_a_q, rd_b_q;
  logic signed [mhpq_pkg::VALUE_W-1:0] mem_wdata;
  logic [mhpq_pkg::ADDR_W-1:0]         mem_waddr, raddr_a, raddr_b;
  logic                                mem_we, mem_re;

  // Sift-down compare terms
  logic [mhpq_pkg::POS_W-1:0]          half_cnt, left_pos, right_pos, dn_next;
  logic signed [mhpq_pkg::VALUE_W-1:0] best_val, dn_child;
  logic                                take_l, take_r;

  // 1-based position to word address
  function automatic logic [mhpq_pkg::ADDR_W-1:0] word_of(
    input logic [mhpq_pkg::POS_W-1:0] p
  );
    logic [mhpq_pkg::POS_W-1:0] w;
    w = p - mhpq_pkg::POS_W'(1);
    return w[mhpq_pkg::ADDR_W-1:0];
  endfunction

  // Word addresses of the left and right children of position p
  function automatic logic [mhpq_pkg::ADDR_W-1:0] left_word(
    input logic [mhpq_pkg::POS_W-1:0] p
  );
    logic [mhpq_pkg::POS_W:0] w;
    w = {p, 1'b0} - (mhpq_pkg::POS_W + 1)'(1);
    return w[mhpq_pkg::ADDR_W-1:0];
  endfunction

  function automatic logic [mhpq_pkg::ADDR_W-1:0] right_word(
    input logic [mhpq_pkg::POS_W-1:0] p
  );
    logic [mhpq_pkg::POS_W:0] w;
    w = {p, 1'b0};
    return w[mhpq_pkg::ADDR_W-1:0];
  endfunction

  assign half_cnt  = cnt_q >> 1;
  assign left_pos  = pos_q << 1;
  assign right_pos = (pos_q << 1) | mhpq_pkg::POS_W'(1);

  // Larger child, left wins a tie; right only if it exists
  always_comb begin
    take_l   = (rd_a_q > val_q);
    best_val = take_l ? rd_a_q : val_q;
    take_r   = (pos_q < half_cnt || (pos_q == half_cnt && cnt_q[0])) &&
               (rd_b_q > best_val);
    dn_next  = take_r ? right_pos : left_pos;
    dn_child = take_r ? rd_b_q : rd_a_q;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    top_d     = top_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    mem_we    = 1'b0;
    mem_waddr = word_of(pos_q);
    mem_wdata = val_q;
    mem_re    = 1'b0;
    raddr_a   = '0;
    raddr_b   = '0;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          op_d  = cmd_i.op;
          val_d = cmd_i.value;
          cnt_d = cmd_i.cnt;
          top_d = '0;
          pos_d = cmd_i.cnt;
          case (cmd_i.op)
            mhpq_pkg::ST_INSERTED: begin
              if (cmd_i.cnt == mhpq_pkg::POS_W'(1)) begin
                state_d = S_PLACE;
              end else begin
                mem_re  = 1'b1;
                raddr_a = word_of(cmd_i.cnt >> 1);
                state_d = S_UP_CMP;
              end
            end
            mhpq_pkg::ST_DEQUEUED: begin
              // root and last entry (old count = new count + 1)
              mem_re  = 1'b1;
              raddr_a = '0;
              raddr_b = cmd_i.cnt[mhpq_pkg::ADDR_W-1:0];
              state_d = S_DN_LOAD;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rd_a_q < val_q) begin
          // parent moves down, hole moves up
          mem_wdata = rd_a_q;
          pos_d     = pos_q >> 1;
          if ((pos_q >> 1) == mhpq_pkg::POS_W'(1)) begin
            state_d = S_PLACE;
          end else begin
            mem_re  = 1'b1;
            raddr_a = word_of(pos_q >> 2);
          end
        end else begin
          state_d = S_RESP;
        end
      end

      S_DN_LOAD: begin
        top_d = rd_a_q;
        val_d = rd_b_q;
        pos_d = mhpq_pkg::POS_W'(1);
        if (cnt_q == '0) begin
          state_d = S_RESP;
        end else if (half_cnt != '0) begin
          mem_re  = 1'b1;
          raddr_a = left_word(mhpq_pkg::POS_W'(1));
          raddr_b = right_word(mhpq_pkg::POS_W'(1));
          state_d = S_DN_CMP;
        end else begin
          state_d = S_PLACE;
        end
      end

      S_DN_CMP: begin
        mem_we = 1'b1;
        if (take_l || take_r) begin
          // larger child moves up, hole moves down
          mem_wdata = dn_child;
          pos_d     = dn_next;
          if (dn_next <= half_cnt) begin
            mem_re  = 1'b1;
            raddr_a = left_word(dn_next);
            raddr_b = right_word(dn_next);
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_RESP;
        end
      end

      S_PLACE: begin
        mem_we  = 1'b1;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    top_q <= top_d;
    cnt_q <= cnt_d;
    pos_q <= pos_d;
    if (out_load) begin
      out_q.status    <= op_q;
      out_q.top_value <= top_q;
      out_q.count     <= mhpq_pkg::COUNT_W'(cnt_q);
    end
  end

  // Heap store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_a_q <= mem_q[raddr_a];
      rd_b_q <= mem_q[raddr_b];
    end
  end

endmodule

### design/max_heap_priority_queue_core.sv
// Flow: a transfer in enters the command queue; the heap engine takes one
// operation at a time from it and sifts level by level, comparing and writing
// while the registered store read for the next level is issued. Full/empty
// reports skip the sift and go straight to the result register.
// Reset clears the entry count, command queue and result valid; the store
// itself is not cleared and holds nothing meaningful until written.
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Binary max-heap priority queue with a classifying front, a command queue
// and a sifting back end.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhpq_in_if.sink    in_i,
  mhpq_out_if.source out_o
);

  mhpq_pkg::cmd_t front_cmd, back_cmd;
  mhpq_pkg::res_t res;
  logic           front_valid, front_ready, back_valid, back_ready;

  mhpq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_value_i  (in_i.value),
    .in_ready_o  (in_i.ready),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  mhpq_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_cmd_o   (back_cmd)
  );

  mhpq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.status    = res.status;
  assign out_o.top_value = res.top_value;
  assign out_o.count     = res.count;

endmodule

### design/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
module mhpq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [1:0]                          out_status_i,
  input logic signed [mhpq_pkg::VALUE_W-1:0] out_top_value_i,
  input logic [mhpq_pkg::COUNT_W-1:0]        out_count_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Empty report carries zero value and zero count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == mhpq_pkg::ST_EMPTY |->
      out_top_value_i == '0 && out_count_i == '0)
    else $error("empty report with nonzero fields");

  // Full report carries zero value and the full count
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == mhpq_pkg::ST_FULL |->
      out_top_value_i == '0 &&
      out_count_i == mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY))
    else $error("full report with wrong fields");

  // An insert leaves at least one entry and no value
  a_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == mhpq_pkg::ST_INSERTED |->
      out_count_i != '0 && out_top_value_i == '0)
    else $error("insert report with wrong fields");

  // A dequeue never leaves the store full
  a_dequeue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == mhpq_pkg::ST_DEQUEUED |->
      out_count_i != mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY))
    else $error("dequeue report with full count");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_top_value_i (out_o.top_value),
  .out_count_i     (out_o.count)
);

### test/max_heap_priority_queue_core_checker.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core_checker
// Watches the request and result channels of the heap priority queue, keeps
// its own max-heap to work out every result, and compares the results field
// by field in transfer order.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mhpq_in_if   req_mon,
  mhpq_out_if  res_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   full_seen_o,
  output int   empty_seen_o,
  output int   peak_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted results still owed by the block, oldest first
  mhpq_pkg::res_t expected_results[$];

  // Shadow heap, positions 1..heap_count live in words 0..heap_count-1
  logic signed [mhpq_pkg::VALUE_W-1:0] heap_words [mhpq_pkg::CAPACITY];
  int unsigned                         heap_count;

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int empty_seen;
  int peak_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign full_seen_o  = full_seen;
  assign empty_seen_o = empty_seen;
  assign peak_count_o = peak_count;

  // Exchange two heap positions (1-based)
  function automatic void swap_positions(int unsigned a, int unsigned b);
    logic signed [mhpq_pkg::VALUE_W-1:0] t;
    t               = heap_words[a-1];
    heap_words[a-1] = heap_words[b-1];
    heap_words[b-1] = t;
  endfunction

  // Apply one operation to the shadow heap and return the result it causes
  function automatic mhpq_pkg::res_t apply_heap_op(
    logic kind, logic signed [mhpq_pkg::VALUE_W-1:0] value
  );
    mhpq_pkg::res_t r;
    int unsigned    pos;
    int unsigned    best;
    int unsigned    left;
    bit             settled;
    r.top_value = '0;
    if (kind == mhpq_pkg::KIND_ENQ) begin
      if (heap_count >= mhpq_pkg::CAPACITY) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        heap_count++;
        heap_words[heap_count-1] = value;
        // sift up while the parent is strictly smaller
        pos = heap_count;
        while (pos > 1 && heap_words[pos/2-1] < heap_words[pos-1]) begin
          swap_positions(pos, pos/2);
          pos = pos / 2;
        end
        r.status = mhpq_pkg::ST_INSERTED;
      end
    end else begin
      if (heap_count == 0) begin
        r.status = mhpq_pkg::ST_EMPTY;
      end else begin
        r.top_value   = heap_words[0];
        heap_words[0] = heap_words[heap_count-1];
        heap_count--;
        // sift down toward the larger child, left wins a tie
        pos     = 1;
        settled = 1'b0;
        while (!settled) begin
          best = pos;
          left = 2 * pos;
          if (left <= heap_count && heap_words[left-1] > heap_words[best-1])
            best = left;
          if (left + 1 <= heap_count && heap_words[left] > heap_words[best-1])
            best = left + 1;
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            swap_positions(pos, best);
            pos = best;
          end
        end
        r.status = mhpq_pkg::ST_DEQUEUED;
      end
    end
    r.count = heap_count[mhpq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // One line per mismatch
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: result %0d: %s got 0x%0h want 0x%0h",
             $time, checked, what, got, want);
    fail_count++;
  endtask

  // Retire results against the oldest expectation, then predict new transfers
  always @(posedge clk_i or negedge rst_ni) begin
    mhpq_pkg::res_t want;
    if (!rst_ni) begin
      expected_results.delete();
      heap_count = 0;
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      full_seen  = 0;
      empty_seen = 0;
      peak_count = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, status",
                          32'(res_mon.status), '0);
        end else begin
          want    = expected_results.pop_front();
          pending = expected_results.size();
          if (res_mon.status !== want.status)
            report_mismatch("status", 32'(res_mon.status), 32'(want.status));
          if (res_mon.top_value !== want.top_value)
            report_mismatch("top_value", 32'(res_mon.top_value), 32'(want.top_value));
          if (res_mon.count !== want.count)
            report_mismatch("count", 32'(res_mon.count), 32'(want.count));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        want = apply_heap_op(req_mon.kind, req_mon.value);
        if (want.status == mhpq_pkg::ST_FULL)  full_seen++;
        if (want.status == mhpq_pkg::ST_EMPTY) empty_seen++;
        if (int'(heap_count) > peak_count) peak_count = int'(heap_count);
        expected_results.push_back(want);
        pending = expected_results.size();
      end
    end
  end

endmodule

### test/max_heap_priority_queue_core_test.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core_test
// Drives enqueue and dequeue requests into the heap priority queue with random
// gaps and result back-pressure; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT   = 18;
  localparam int STALL_MAX  = 5000;  // cycles without any transfer
  localparam int DRAIN_WAIT = 40;    // idle wait after the last result is checked

  logic clk_i;
  logic rst_ni;
  logic steady;   // no idling on either side while set

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int empty_seen;
  int peak_count;
  int sent;
  int stall_cycles;

  mhpq_in_if  req_if ();
  mhpq_out_if res_if ();

  max_heap_priority_queue_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  max_heap_priority_queue_core_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .full_seen_o  (full_seen),
    .empty_seen_o (empty_seen),
    .peak_count_o (peak_count)
  );

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("timeout: no transfer for %0d cycles, %0d results owed",
                 stall_cycles, pending);
        $display("max_heap_priority_queue_core test failed");
        $finish;
      end
    end
  end

  // Priority values: full range, a narrow band for ties, and the extremes
  function automatic logic signed [mhpq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      4, 5, 6: pick_value = $signed($urandom_range(15)) - 8;
      7: begin
        case ($urandom_range(3))
          0:       pick_value = 32'sh7fff_ffff;
          1:       pick_value = 32'sh8000_0000;
          2:       pick_value = '0;
          default: pick_value = -1;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // One request transfer, with random idle cycles in front of it
  task automatic send_request(mhpq_pkg::kind_e kind,
                              logic signed [mhpq_pkg::VALUE_W-1:0] value);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  // Random requests, enqueue chosen enq_pct percent of the time
  task automatic run_phase(int items, int enq_pct);
    repeat (items) begin
      if ($urandom_range(99) < enq_pct) send_request(mhpq_pkg::KIND_ENQ, pick_value());
      else                              send_request(mhpq_pkg::KIND_DEQ, $urandom);
    end
  endtask

  initial begin
    sent          = 0;
    steady       <= 1'b0;
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.kind  <= mhpq_pkg::KIND_ENQ;
    req_if.value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty dequeue, extremes, ties, drain past the last entry
    send_request(mhpq_pkg::KIND_DEQ, 32'sh1234_5678);
    send_request(mhpq_pkg::KIND_ENQ, 32'sh7fff_ffff);
    send_request(mhpq_pkg::KIND_ENQ, 32'sh8000_0000);
    send_request(mhpq_pkg::KIND_ENQ, '0);
    send_request(mhpq_pkg::KIND_ENQ, -1);
    send_request(mhpq_pkg::KIND_ENQ, 5);
    send_request(mhpq_pkg::KIND_ENQ, 5);
    send_request(mhpq_pkg::KIND_ENQ, 5);
    send_request(mhpq_pkg::KIND_ENQ, 32'sh5555_5555);
    send_request(mhpq_pkg::KIND_ENQ, 32'shAAAA_AAAA);
    repeat (10) send_request(mhpq_pkg::KIND_DEQ, $urandom);
    send_request(mhpq_pkg::KIND_ENQ, 32'sh8000_0000);
    send_request(mhpq_pkg::KIND_DEQ, '0);
    send_request(mhpq_pkg::KIND_DEQ, '1);

    // Fill past full, drain past empty, then a mixed walk
    run_phase(220, 90);
    run_phase(220, 10);
    steady <= 1'b1;
    run_phase(150, 55);
    steady <= 1'b0;
    run_phase(160, 85);
    run_phase(250, 50);
    req_if.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked", sent, checked);
    $display("store peaked at %0d entries; %0d refused when full, %0d empty dequeues",
             peak_count, full_seen, empty_seen);
    if (fail_count == 0 && pending == 0 && checked == sent) begin
      $display("max_heap_priority_queue_core test passed");
    end else begin
      $display("max_heap_priority_queue_core test failed");
    end
    $finish;
  end

endmodule
